// ----- rtl/mm4_pkg.sv -----
// ----------------------------------------------------------------------------
// mm4_pkg: shared types and constants for the 4x4 matrix multiplier
// Holds the parameter defaults, the controller state encoding and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mm4_pkg;

  // Parameter defaults
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed port widths
  localparam int DATA_WIDTH = 32;
  localparam int IDX_WIDTH  = 4;
  localparam int POS_WIDTH  = 5;
  localparam int STEP_WIDTH = 6;

  // Last load slot (B[15]) and last result index
  localparam logic [POS_WIDTH-1:0]  LAST_SLOT  = 5'd31;
  localparam logic [IDX_WIDTH-1:0]  LAST_INDEX = 4'd15;
  localparam logic [STEP_WIDTH-1:0] LAST_STEP  = 6'd63;
  localparam logic [1:0]            FIRST_TERM = 2'd0;
  localparam logic [1:0]            LAST_TERM  = 2'd3;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                 wr_a;
    logic                 wr_b;
    logic [IDX_WIDTH-1:0] wr_addr;
    logic                 rd_en;
    logic [IDX_WIDTH-1:0] rd_idx;
    logic [1:0]           rd_k;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic final_done;
  } status_t;

endpackage

// ----- rtl/mm4_ctrl.sv -----
// ----------------------------------------------------------------------------
// mm4_ctrl: load and compute sequencer
// Tracks the load position, steers element writes into the A or B store and
// walks the 64 multiply-accumulate steps once a full pair is stored.
// ----------------------------------------------------------------------------
module mm4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_start_req,
  output logic              busy,
  output mm4_pkg::cmd_t     cmd,
  input  mm4_pkg::status_t  status
);

  mm4_pkg::state_t                     state_r, state_nxt;
  logic [mm4_pkg::POS_WIDTH-1:0]       pos_r, pos_nxt;
  logic [mm4_pkg::STEP_WIDTH-1:0]      step_r, step_nxt;
  logic [mm4_pkg::POS_WIDTH-1:0]       slot;
  logic                                accept;

  // Resolve the slot for this transfer
  assign accept = start && (state_r == mm4_pkg::ST_LOAD);
  assign slot   = in_start_req ? '0 : pos_r;
  assign busy   = (state_r != mm4_pkg::ST_LOAD);

  // Drive commands to the datapath
  always_comb begin
    cmd         = '0;
    cmd.wr_a    = accept && !slot[mm4_pkg::POS_WIDTH-1];
    cmd.wr_b    = accept && slot[mm4_pkg::POS_WIDTH-1];
    cmd.wr_addr = slot[mm4_pkg::IDX_WIDTH-1:0];
    cmd.rd_en   = (state_r == mm4_pkg::ST_RUN);
    cmd.rd_idx  = step_r[mm4_pkg::STEP_WIDTH-1:2];
    cmd.rd_k    = step_r[1:0];
  end

  // Next state, position and step
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    case (state_r)
      mm4_pkg::ST_LOAD: begin
        if (accept) begin
          pos_nxt = slot + 5'd1;
          if (slot == mm4_pkg::LAST_SLOT) begin
            state_nxt = mm4_pkg::ST_RUN;
            step_nxt  = '0;
          end
        end
      end
      mm4_pkg::ST_RUN: begin
        step_nxt = step_r + 6'd1;
        if (step_r == mm4_pkg::LAST_STEP) begin
          state_nxt = mm4_pkg::ST_DRAIN;
        end
      end
      mm4_pkg::ST_DRAIN: begin
        if (status.final_done) begin
          state_nxt = mm4_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = mm4_pkg::ST_LOAD;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm4_pkg::ST_LOAD;
      pos_r   <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- rtl/mm4_datapath.sv -----
// ----------------------------------------------------------------------------
// mm4_datapath: element stores and multiply-accumulate pipeline
// Two 16-entry stores hold A and B. Each step reads one pair, multiplies,
// and accumulates four products; the fourth is shifted, saturated and shown.
// ----------------------------------------------------------------------------
module mm4_datapath #(
  parameter int ELEM_WIDTH = mm4_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mm4_pkg::cmd_t                     cmd,
  input  logic [mm4_pkg::DATA_WIDTH-1:0]    in_element,
  output mm4_pkg::status_t                  status,
  output logic                              out_valid,
  output logic [mm4_pkg::DATA_WIDTH-1:0]    out_product_value,
  output logic [mm4_pkg::IDX_WIDTH-1:0]     out_product_index,
  output logic                              out_last_result
);

  localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 2;

  logic [ELEM_WIDTH-1:0]            a_mem [16];
  logic [ELEM_WIDTH-1:0]            b_mem [16];
  logic [mm4_pkg::IDX_WIDTH-1:0]    a_addr, b_addr;

  logic signed [ELEM_WIDTH-1:0]     a_q, b_q;
  logic                             v1_r, first1_r, last1_r;
  logic [mm4_pkg::IDX_WIDTH-1:0]    idx1_r;

  logic signed [PROD_WIDTH-1:0]     prod_r;
  logic                             v2_r, first2_r, last2_r;
  logic [mm4_pkg::IDX_WIDTH-1:0]    idx2_r;

  logic signed [ACC_WIDTH-1:0]      acc_r;
  logic signed [ACC_WIDTH-1:0]      prod_ext;
  logic                             v3_r, last3_r;
  logic [mm4_pkg::IDX_WIDTH-1:0]    idx3_r;

  logic signed [ACC_WIDTH-1:0]      shifted;
  logic [ACC_WIDTH-ELEM_WIDTH:0]    upper;
  logic signed [ELEM_WIDTH-1:0]     sat_val;
  logic                             emit;

  logic                             out_valid_r;
  logic [mm4_pkg::DATA_WIDTH-1:0]   value_r;
  logic [mm4_pkg::IDX_WIDTH-1:0]    index_r;
  logic                             last_r;

  // A[r*4+k] and B[k*4+c] for result r*4+c
  assign a_addr = {cmd.rd_idx[3:2], cmd.rd_k};
  assign b_addr = {cmd.rd_k, cmd.rd_idx[1:0]};

  // Store incoming elements, read one pair per step
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[cmd.wr_addr] <= in_element[ELEM_WIDTH-1:0];
    end
    if (cmd.wr_b) begin
      b_mem[cmd.wr_addr] <= in_element[ELEM_WIDTH-1:0];
    end
    if (cmd.rd_en) begin
      a_q <= a_mem[a_addr];
      b_q <= b_mem[b_addr];
    end
  end

  // Multiply the read pair
  always_ff @(posedge clk) begin
    prod_r <= PROD_WIDTH'(a_q) * PROD_WIDTH'(b_q);
  end

  // Accumulate four products, restart on the first term
  assign prod_ext = {{2{prod_r[PROD_WIDTH-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= first2_r ? prod_ext : acc_r + prod_ext;
    end
  end

  // Scale and saturate the finished sum
  assign shifted = acc_r >>> FRAC_BITS;
  assign upper   = shifted[ACC_WIDTH-1:ELEM_WIDTH-1];
  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat_val = shifted[ELEM_WIDTH-1:0];
    end else if (shifted[ACC_WIDTH-1]) begin
      sat_val = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    end
  end

  assign emit              = v3_r && last3_r;
  assign status.final_done = emit && (idx3_r == mm4_pkg::LAST_INDEX);

  // Result register
  always_ff @(posedge clk) begin
    if (emit) begin
      value_r <= mm4_pkg::DATA_WIDTH'(sat_val);
      index_r <= idx3_r;
      last_r  <= (idx3_r == mm4_pkg::LAST_INDEX);
    end
  end

  // Advance step tags through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.rd_en;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (cmd.rd_k == mm4_pkg::FIRST_TERM);
    last1_r  <= (cmd.rd_k == mm4_pkg::LAST_TERM);
    idx1_r   <= cmd.rd_idx;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    idx2_r   <= idx1_r;
    last3_r  <= last2_r;
    idx3_r   <= idx2_r;
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = value_r;
  assign out_product_index = index_r;
  assign out_last_result   = last_r;

endmodule

// ----- rtl/matrix4_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix4_multiply: 4x4 fixed-point matrix product, 16 saturated dot products
// Loads A then B one element per cycle while busy is low.
// ----------------------------------------------------------------------------
// Load: one element transfer per cycle while busy is low, 32 per pair.
// Compute: results follow the 32nd transfer in index order from one shared
// multiplier, four terms each; busy is high from the end of the load until
// the final result is shown, so a new pair cannot load before that result.
// Reset clears the load position and controller; results are never stalled.
// ----------------------------------------------------------------------------
module matrix4_multiply #(
  parameter int ELEM_WIDTH = mm4_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mm4_pkg::DATA_WIDTH-1:0]    in_element,
  input  logic                              in_start_req,
  output logic                              out_valid,
  output logic [mm4_pkg::DATA_WIDTH-1:0]    out_product_value,
  output logic [mm4_pkg::IDX_WIDTH-1:0]     out_product_index,
  output logic                              out_last_result
);

  mm4_pkg::cmd_t    cmd;
  mm4_pkg::status_t status;

  // Sequencer
  mm4_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_start_req (in_start_req),
    .busy         (busy),
    .cmd          (cmd),
    .status       (status)
  );

  // Stores and multiply-accumulate
  mm4_datapath #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_element        (in_element),
    .status            (status),
    .out_valid         (out_valid),
    .out_product_value (out_product_value),
    .out_product_index (out_product_index),
    .out_last_result   (out_last_result)
  );

endmodule

// ----- rtl/mm4_checker.sv -----
// ----------------------------------------------------------------------------
// mm4_checker: port-level checks for the matrix multiplier
// Checks result spacing, ordering and how busy tracks the result burst.
// ----------------------------------------------------------------------------
module mm4_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              busy,
  input logic                              out_valid,
  input logic [mm4_pkg::IDX_WIDTH-1:0]     out_product_index,
  input logic                              out_last_result
);

  // Results never come back to back
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe in consecutive cycles");

  // Each non-final result is followed by a result for the next index
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> ##4
      (out_valid && (out_product_index == 4'($past(out_product_index, 4) + 4'd1))))
    else $error("result missing or out of order");

  // Busy stays high through the burst and drops with the final result
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> busy)
    else $error("busy low during result burst");

  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && out_last_result))
    else $error("busy dropped without final result");

  // Final flag only on the last index
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |-> (out_product_index == mm4_pkg::LAST_INDEX))
    else $error("final flag on wrong index");

endmodule

bind matrix4_multiply mm4_checker u_mm4_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_product_index (out_product_index),
  .out_last_result   (out_last_result)
);
